// File: design/rpmd_pkg.sv
// Shared types, widths and constants for the RC pulse motor drive block.
// No dependencies; every other file in the design folder imports this package.
package rpmd_pkg;

  localparam int AvgShiftDefault = 2;

  localparam int TsW     = 16;
  localparam int PulseW  = 17;
  localparam int WindowW = 16;
  localparam int ByteW   = 8;
  localparam int SumW    = 24;
  localparam int OdoW    = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 17;

  localparam logic [PulseW-1:0]  PulseMinReset     = 17'd1600;
  localparam logic [PulseW-1:0]  PulseMaxReset     = 17'd4400;
  localparam logic [PulseW-1:0]  PulseCenterReset  = 17'd3000;
  localparam logic [WindowW-1:0] CenterWindowReset = 16'd100;
  localparam logic [WindowW-1:0] SpanReset         = 16'd1000;
  localparam logic [ByteW-1:0]   DeadZoneReset     = 8'd20;
  localparam logic [ByteW-1:0]   ArmCountReset     = 8'd12;
  localparam logic [ByteW-1:0]   TimeoutTicksReset = 8'd8;

  // q + q/50 reaches 255 at q = 250; above that the duty saturates.
  localparam logic [ByteW-1:0] DutyMax     = 8'd255;
  localparam logic [ByteW-1:0] DutySatQ    = 8'd250;
  // q/50 for q <= 255 as (q * 41) >> 11.
  localparam logic [5:0]       Div50Mul    = 6'd41;
  localparam int               Div50Shift  = 11;

  typedef enum logic [1:0] {
    ReqRise     = 2'd0,
    ReqFall     = 2'd1,
    ReqOverflow = 2'd2,
    ReqFeedback = 2'd3
  } req_kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegPulseMin     = 3'd0,
    RegPulseMax     = 3'd1,
    RegPulseCenter  = 3'd2,
    RegCenterWindow = 3'd3,
    RegSpan         = 3'd4,
    RegDeadZone     = 3'd5,
    RegArmCount     = 3'd6,
    RegTimeoutTicks = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [PulseW-1:0]  pulse_min;
    logic [PulseW-1:0]  pulse_max;
    logic [PulseW-1:0]  pulse_center;
    logic [WindowW-1:0] center_window;
    logic [WindowW-1:0] full_scale_span;
    logic [ByteW-1:0]   dead_zone;
    logic [ByteW-1:0]   arm_count;
    logic [ByteW-1:0]   timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]     req_type;
    logic [TsW-1:0] timestamp;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0]       duty;
    logic                   direction;
    logic                   led_on;
    logic                   armed;
    logic signed [OdoW-1:0] odometer;
    logic [PulseW-1:0]      avg_width;
  } result_t;

endpackage

// File: design/rpmd_if.sv
// Valid/ready channel interfaces for the event input and the result output.
// Depends on rpmd_pkg for field widths.
interface rpmd_req_if import rpmd_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [1:0]     req_type;
  logic [TsW-1:0] timestamp;

  modport source (output valid, req_type, timestamp, input ready);
  modport sink (input valid, req_type, timestamp, output ready);
endinterface

interface rpmd_res_if import rpmd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ByteW-1:0]       duty;
  logic                   direction;
  logic                   led_on;
  logic                   armed;
  logic signed [OdoW-1:0] odometer;
  logic [PulseW-1:0]      avg_width;

  modport source (output valid, duty, direction, led_on, armed, odometer, avg_width,
                  input ready);
  modport sink (input valid, duty, direction, led_on, armed, odometer, avg_width,
                output ready);
endinterface

// File: design/rpmd_cfg_regs.sv
// Configuration register file: eight write-only registers with reset values.
// Depends on rpmd_pkg.
module rpmd_cfg_regs import rpmd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_min       <= PulseMinReset;
      cfg.pulse_max       <= PulseMaxReset;
      cfg.pulse_center    <= PulseCenterReset;
      cfg.center_window   <= CenterWindowReset;
      cfg.full_scale_span <= SpanReset;
      cfg.dead_zone       <= DeadZoneReset;
      cfg.arm_count       <= ArmCountReset;
      cfg.timeout_ticks   <= TimeoutTicksReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        RegPulseMin:     cfg.pulse_min       <= cfg_data;
        RegPulseMax:     cfg.pulse_max       <= cfg_data;
        RegPulseCenter:  cfg.pulse_center    <= cfg_data;
        RegCenterWindow: cfg.center_window   <= cfg_data[WindowW-1:0];
        RegSpan:         cfg.full_scale_span <= cfg_data[WindowW-1:0];
        RegDeadZone:     cfg.dead_zone       <= cfg_data[ByteW-1:0];
        RegArmCount:     cfg.arm_count       <= cfg_data[ByteW-1:0];
        RegTimeoutTicks: cfg.timeout_ticks   <= cfg_data[ByteW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/rpmd_duty_map.sv
// Maps an averaged pulse width to motor direction and PWM duty.
// Depends on rpmd_pkg; purely combinational.
module rpmd_duty_map import rpmd_pkg::*; (
  input  logic [PulseW-1:0] avg,
  input  cfg_t              cfg,
  output logic [ByteW-1:0]  duty,
  output logic              direction
);

  logic [PulseW-1:0]  distance;
  logic [WindowW-1:0] dist_clamped;
  logic [13:0]        q;
  logic [ByteW-1:0]   q_low;
  logic [13:0]        prod;
  logic [ByteW-1:0]   p;

  always_comb begin
    direction    = (avg > cfg.pulse_center);
    distance     = direction ? (avg - cfg.pulse_center) : (cfg.pulse_center - avg);
    dist_clamped = (distance > {1'b0, cfg.full_scale_span}) ? cfg.full_scale_span
                                                            : distance[WindowW-1:0];
    q            = dist_clamped[WindowW-1:2];
    q_low        = q[ByteW-1:0];
    prod         = 14'(q_low) * 14'(Div50Mul);
    // Past the saturation point the exact quotient no longer matters.
    if (q > 14'(DutySatQ)) begin
      p = DutyMax;
    end else begin
      p = q_low + ByteW'(prod >> Div50Shift);
    end
    duty = (p < cfg.dead_zone) ? '0 : p;
  end

endmodule

// File: design/rpmd_state_update.sv
// Event state: edge timing, width averaging, arming, failsafe timeout and odometer.
// Depends on rpmd_pkg and rpmd_duty_map. Updates its state once per fired item.
module rpmd_state_update import rpmd_pkg::*; #(
  parameter int AVG_SHIFT = AvgShiftDefault
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    item_fire,
  input  item_t   item,
  output result_t result_next
);

  localparam int CntW = AVG_SHIFT + 1;
  localparam logic [CntW-1:0] CntFull = CntW'(2 ** AVG_SHIFT);

  logic [1:0]             overflow_count, overflow_count_next;
  logic [TsW-1:0]         rise_time, rise_time_next;
  logic [SumW-1:0]        width_sum, width_sum_next;
  logic [CntW-1:0]        sum_count, sum_count_next;
  logic [PulseW-1:0]      average_width, average_width_next;
  logic                   armed_flag, armed_flag_next;
  logic [ByteW-1:0]       arm_progress, arm_progress_next;
  logic [ByteW-1:0]       timeout_progress, timeout_progress_next;
  logic                   led_level, led_level_next;
  logic                   dir_level, dir_level_next;
  logic [ByteW-1:0]       duty_value, duty_value_next;
  logic [OdoW-1:0]        edge_count, edge_count_next;

  logic signed [19:0]     width;
  logic signed [19:0]     win_lo;
  logic signed [19:0]     win_hi;
  logic                   in_range;
  logic                   centered;
  logic [SumW-1:0]        sum_add;
  logic [CntW-1:0]        cnt_inc;
  logic [PulseW-1:0]      avg_new;
  logic [1:0]             ovf_inc;
  logic [ByteW-1:0]       tp_inc;
  logic [ByteW-1:0]       ap_inc;
  logic [ByteW-1:0]       map_duty;
  logic                   map_dir;

  rpmd_duty_map u_duty_map (
    .avg       (avg_new),
    .cfg       (cfg),
    .duty      (map_duty),
    .direction (map_dir)
  );

  always_comb begin
    // The overflow count extends the timestamp above bit 15.
    width    = $signed({2'b00, overflow_count, item.timestamp})
             - $signed({4'b0000, rise_time});
    in_range = !width[19] && (width[18:0] > {2'b00, cfg.pulse_min})
                          && (width[18:0] < {2'b00, cfg.pulse_max});
    win_lo   = $signed({3'b000, cfg.pulse_center}) - $signed({4'b0000, cfg.center_window});
    win_hi   = $signed({3'b000, cfg.pulse_center}) + $signed({4'b0000, cfg.center_window});
    centered = (width > win_lo) && (width < win_hi);
    sum_add  = width_sum + SumW'(width[PulseW-1:0]);
    cnt_inc  = sum_count + 1'b1;
    avg_new  = sum_add[AVG_SHIFT +: PulseW];
    ovf_inc  = overflow_count + 1'b1;
    tp_inc   = timeout_progress + 1'b1;
    ap_inc   = arm_progress + 1'b1;
  end

  always_comb begin
    overflow_count_next   = overflow_count;
    rise_time_next        = rise_time;
    width_sum_next        = width_sum;
    sum_count_next        = sum_count;
    average_width_next    = average_width;
    armed_flag_next       = armed_flag;
    arm_progress_next     = arm_progress;
    timeout_progress_next = timeout_progress;
    led_level_next        = led_level;
    dir_level_next        = dir_level;
    duty_value_next       = duty_value;
    edge_count_next       = edge_count;

    unique case (req_kind_t'(item.req_type))
      ReqRise: begin
        overflow_count_next = '0;
        rise_time_next      = item.timestamp;
      end
      ReqFall: begin
        if (in_range) begin
          if (cnt_inc == CntFull) begin
            average_width_next = avg_new;
            width_sum_next     = '0;
            sum_count_next     = '0;
            if (armed_flag) begin
              led_level_next  = !led_level;
              dir_level_next  = map_dir;
              duty_value_next = map_duty;
            end else if (centered) begin
              led_level_next = 1'b1;
              if (ap_inc == cfg.arm_count) begin
                armed_flag_next   = 1'b1;
                arm_progress_next = '0;
              end else begin
                arm_progress_next = ap_inc;
              end
            end else begin
              arm_progress_next = '0;
              led_level_next    = 1'b0;
            end
          end else begin
            width_sum_next = sum_add;
            sum_count_next = cnt_inc;
          end
        end else begin
          led_level_next = 1'b0;
        end
      end
      ReqOverflow: begin
        // Two overflows without a rising edge make one timeout tick.
        if (ovf_inc == 2'd2) begin
          overflow_count_next = '0;
          if (tp_inc == cfg.timeout_ticks) begin
            led_level_next        = !led_level;
            timeout_progress_next = '0;
            duty_value_next       = '0;
          end else begin
            timeout_progress_next = tp_inc;
          end
        end else begin
          overflow_count_next = ovf_inc;
        end
      end
      ReqFeedback: begin
        edge_count_next = dir_level ? (edge_count + 1'b1) : (edge_count - 1'b1);
      end
      default: ;
    endcase

    result_next.duty      = duty_value_next;
    result_next.direction = dir_level_next;
    result_next.led_on    = led_level_next;
    result_next.armed     = armed_flag_next;
    result_next.odometer  = $signed(edge_count_next);
    result_next.avg_width = average_width_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_count   <= '0;
      rise_time        <= '0;
      width_sum        <= '0;
      sum_count        <= '0;
      average_width    <= '0;
      armed_flag       <= 1'b0;
      arm_progress     <= '0;
      timeout_progress <= '0;
      led_level        <= 1'b0;
      dir_level        <= 1'b0;
      duty_value       <= '0;
      edge_count       <= '0;
    end else if (item_fire) begin
      overflow_count   <= overflow_count_next;
      rise_time        <= rise_time_next;
      width_sum        <= width_sum_next;
      sum_count        <= sum_count_next;
      average_width    <= average_width_next;
      armed_flag       <= armed_flag_next;
      arm_progress     <= arm_progress_next;
      timeout_progress <= timeout_progress_next;
      led_level        <= led_level_next;
      dir_level        <= dir_level_next;
      duty_value       <= duty_value_next;
      edge_count       <= edge_count_next;
    end
  end

endmodule

// File: design/rc_pulse_motor_drive_core.sv
// RC servo pulse decoder for one motor: events in, direction, duty and status out.
// Depends on rpmd_pkg, rpmd_if, rpmd_cfg_regs and rpmd_state_update.
//
// Every event (pulse rising edge, pulse falling edge, timer overflow, feedback
// edge) produces exactly one result word that shows duty, direction, LED level,
// armed flag, odometer and latest average after that event. The block takes one
// event word per clock while the output is not stalled; a word is captured in an
// input register, processed by the combinational update logic, and its result is
// loaded into the output register when the output is free or being read. The state
// update of one event must finish before the next is processed, which sets the
// rate at one word per clock while the output is not stalled. While the output
// is stalled the input register still takes one more word. Configuration writes
// take effect on the next clock edge and are meant to be issued while no event
// is in flight.
module rc_pulse_motor_drive_core import rpmd_pkg::*; #(
  parameter int AVG_SHIFT = AvgShiftDefault
) (
  input  logic                clk,
  input  logic                rst,
  rpmd_req_if.sink            req,
  rpmd_res_if.source          res,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t result_next;
  logic    advance;
  logic    fire;

  rpmd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpmd_state_update #(
    .AVG_SHIFT (AVG_SHIFT)
  ) u_state_update (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_fire   (fire),
    .item        (in_item),
    .result_next (result_next)
  );

  assign advance   = !out_valid || res.ready;
  assign fire      = in_valid && advance;
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.req_type  <= req.req_type;
      in_item.timestamp <= req.timestamp;
    end
    if (fire) begin
      out_res <= result_next;
    end
  end

  assign res.valid     = out_valid;
  assign res.duty      = out_res.duty;
  assign res.direction = out_res.direction;
  assign res.led_on    = out_res.led_on;
  assign res.armed     = out_res.armed;
  assign res.odometer  = out_res.odometer;
  assign res.avg_width = out_res.avg_width;

endmodule

// File: design/rpmd_checker.sv
// Port-level checks for the RC pulse motor drive block, bound to the top level.
// Depends on rpmd_pkg and rc_pulse_motor_drive_core.
module rpmd_checker import rpmd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic [ByteW-1:0]       res_duty,
  input logic                   res_armed,
  input logic signed [OdoW-1:0] res_odometer
);

  logic                   out_fire;
  logic                   armed_seen;
  logic                   odo_seen;
  logic signed [OdoW-1:0] last_odo;

  assign out_fire = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_seen <= 1'b0;
      odo_seen   <= 1'b0;
    end else if (out_fire) begin
      armed_seen <= armed_seen || res_armed;
      odo_seen   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      last_odo <= res_odometer;
    end
  end

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_duty) && $stable(res_odometer))
    else $error("stalled result word changed");

  // Once armed, the block stays armed until reset.
  a_armed_sticky: assert property (@(posedge clk) disable iff (rst)
    out_fire && armed_seen |-> res_armed)
    else $error("armed flag dropped without reset");

  // Each word is one event, so the odometer moves by at most one count.
  a_odometer_step: assert property (@(posedge clk) disable iff (rst)
    out_fire && odo_seen |-> (res_odometer == last_odo)
      || (res_odometer == last_odo + 32'sd1) || (res_odometer == last_odo - 32'sd1))
    else $error("odometer jumped by more than one count");

  a_duty_needs_arm: assert property (@(posedge clk) disable iff (rst)
    out_fire && (res_duty != '0) |-> res_armed)
    else $error("nonzero duty before arming");

endmodule

bind rc_pulse_motor_drive_core rpmd_checker u_rpmd_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_duty     (res.duty),
  .res_armed    (res.armed),
  .res_odometer (res.odometer)
);
